>>> rtl/core/dwm_pkg.sv
package dwm_pkg;

    localparam int COORD_BITS = 12;
    localparam int DEPTH_BITS = 16;
    localparam int DIM_BITS   = 13;
    localparam int WIN_BITS   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int BIT_IDX_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;

    localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RST  = 13'd640;
    localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RST = 13'd480;
    localparam logic [WIN_BITS-1:0] WINDOW_SIZE_RST  = 5'd5;

    typedef struct packed {
        logic [COORD_BITS-1:0] sample_col;
        logic [COORD_BITS-1:0] sample_row;
        logic [COORD_BITS-1:0] center_col;
        logic [COORD_BITS-1:0] center_row;
        logic [DEPTH_BITS-1:0] depth_mm;
        logic                  depth_finite;
        logic                  last;
    } in_item_t;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] median_depth_mm;
        logic                  found;
        logic                  overflow;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic init;
        logic scan;
        logic decide;
        logic load_out;
    } dwm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic bit_zero;
        logic out_free;
    } dwm_stat_t;

endpackage

>>> rtl/core/depth_window_median_top.sv
// Input: one beat per cycle while a batch is collected; s_ready drops after the last beat.
// After the last beat, an empty batch goes straight to the output; otherwise the median of the
// N kept samples is selected with one pass over the sample RAM per depth bit, one read per cycle.
// The result sits in an output register, so the next batch streams in while it waits.
// Reset (aresetn, synchronous, active low) empties the batch, drops m_valid and restores
// image 640 x 480 with window size 5; the sample RAM itself is not cleared.
module depth_window_median_top #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample beats
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dwm_pkg::in_item_t             s_data,
    // result beats
    output logic                          m_valid,
    input  logic                          m_ready,
    output dwm_pkg::out_item_t            m_data,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dwm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dwm_pkg::DIM_BITS-1:0]  cfg_data
);
    import dwm_pkg::*;

    dwm_cmd_t  cmd;
    dwm_stat_t stat;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // sequence the batch: collect, then select the median bit by bit, then hand off
    dwm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // filter, sample RAM, rank counters and output register
    dwm_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

>>> rtl/core/dwm_ctrl.sv
module dwm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_last,
    output logic             s_ready,
    output dwm_pkg::dwm_cmd_t cmd,
    input  dwm_pkg::dwm_stat_t stat
);
    import dwm_pkg::*;

    typedef enum logic [5:0] {
        ST_ACCEPT = 6'b000001,
        ST_START  = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_ACCEPT);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = s_ready && s_valid;
        unique case (state_reg)
            ST_ACCEPT: begin
                if (s_valid && s_last) state_next = ST_START;
            end
            ST_START: begin
                if (stat.count_zero) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.init   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = stat.bit_zero ? ST_OUT : ST_SCAN;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCEPT;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCEPT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/dwm_dp.sv
module dwm_dp #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dwm_pkg::in_item_t                s_data,
    input  logic                             cfg_valid,
    input  logic [dwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dwm_pkg::DIM_BITS-1:0]     cfg_data,
    input  dwm_pkg::dwm_cmd_t                cmd,
    output dwm_pkg::dwm_stat_t               stat,
    input  logic                             m_ready,
    output logic                             m_valid,
    output dwm_pkg::out_item_t               m_data
);
    import dwm_pkg::*;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int POS_W  = COORD_BITS + 1;

    logic [DIM_BITS-1:0]   image_width_reg;
    logic [DIM_BITS-1:0]   image_height_reg;
    logic [WIN_BITS-1:0]   window_size_reg;

    logic [DEPTH_BITS-1:0] store_mem [STORE_DEPTH];
    logic [DEPTH_BITS-1:0] rd_data_reg;
    logic                  rd_vld_reg;

    logic [CNT_W-1:0]      count_reg;
    logic                  dropped_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [CNT_W-1:0]      tally_reg;
    logic [CNT_W-1:0]      rank_reg;
    logic [DEPTH_BITS-1:0] prefix_reg;
    logic [BIT_IDX_W-1:0]  bit_reg;

    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    logic [POS_W-1:0]      radius;
    logic                  col_ok, row_ok, keep, full;
    logic [DEPTH_BITS-1:0] hi_mask;
    logic                  match;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
            window_size_reg  <= WINDOW_SIZE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_WINDOW_SIZE:  window_size_reg  <= cfg_data[WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // window test: centre - r <= pos < min(centre + r, size)
    assign radius = POS_W'(window_size_reg >> 1);
    assign col_ok = (POS_W'(s_data.sample_col) + radius >= POS_W'(s_data.center_col))
                 && (POS_W'(s_data.sample_col) <  POS_W'(s_data.center_col) + radius)
                 && (DIM_BITS'(s_data.sample_col) < image_width_reg);
    assign row_ok = (POS_W'(s_data.sample_row) + radius >= POS_W'(s_data.center_row))
                 && (POS_W'(s_data.sample_row) <  POS_W'(s_data.center_row) + radius)
                 && (DIM_BITS'(s_data.sample_row) < image_height_reg);
    assign keep   = s_data.depth_finite && (s_data.depth_mm != '0) && col_ok && row_ok;
    assign full   = (count_reg == CNT_W'(STORE_DEPTH));

    // store
    always_ff @(posedge aclk) begin
        if (cmd.accept && keep && !full) begin
            store_mem[count_reg[ADDR_W-1:0]] <= s_data.depth_mm;
        end
        rd_data_reg <= store_mem[addr_reg];
    end

    // radix select: one pass over the store per depth bit, MSB first
    assign hi_mask = {DEPTH_BITS{1'b1}} << ({1'b0, bit_reg} + 5'd1);
    assign match   = (((rd_data_reg ^ prefix_reg) & hi_mask) == '0) && !rd_data_reg[bit_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan;
            if (cmd.load_out) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else if (cmd.accept && keep) begin
                if (full) dropped_reg <= 1'b1;
                else      count_reg   <= count_reg + CNT_W'(1);
            end
            if (cmd.load_out)  m_valid_reg <= 1'b1;
            else if (m_ready)  m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            addr_reg   <= '0;
            tally_reg  <= '0;
            rank_reg   <= count_reg >> 1;
            prefix_reg <= '0;
            bit_reg    <= '1;
        end else if (cmd.decide) begin
            addr_reg  <= '0;
            tally_reg <= '0;
            bit_reg   <= bit_reg - BIT_IDX_W'(1);
            if (rank_reg >= tally_reg) begin
                prefix_reg[bit_reg] <= 1'b1;
                rank_reg            <= rank_reg - tally_reg;
            end
        end else begin
            if (cmd.scan) addr_reg <= addr_reg + ADDR_W'(1);
            if (rd_vld_reg && match) tally_reg <= tally_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg.found           <= (count_reg != '0);
            m_data_reg.median_depth_mm <= (count_reg != '0) ? prefix_reg : '0;
            m_data_reg.overflow        <= dropped_reg;
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_last  = (CNT_W'(addr_reg) == count_reg - CNT_W'(1));
    assign stat.bit_zero   = (bit_reg == '0);
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> rtl/core/dwm_checker.sv
module dwm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input dwm_pkg::in_item_t   s_data,
    input logic                m_valid,
    input logic                m_ready,
    input dwm_pkg::out_item_t  m_data
);
    import dwm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // a batch end stops intake for selection
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last |=> !s_ready)
        else $error("intake open right after batch end");

    // mid-batch beats keep intake open
    a_mid_open: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.last |=> s_ready)
        else $error("intake closed mid-batch");

    // empty batch reports zero depth
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.median_depth_mm == '0)
        else $error("nonzero depth without a kept sample");

endmodule

bind depth_window_median_top dwm_checker u_dwm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> dv/tb_depth_window_median_top.sv
`timescale 1ns / 100ps

module tb_depth_window_median_top;

    import dwm_pkg::*;

    localparam int STORE_DEPTH = 256;
    // long receiver hold-off, in cycles, so the block fills up and drops s_ready
    localparam int LONG_STALL = 2000;
    // quiet cycles after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [DIM_BITS-1:0]  cfg_data = '0;

    // one row of the directed table: a sample beat and, where it is obvious,
    // the result it must produce
    typedef struct {
        in_item_t  beat;
        bit        typed;
        out_item_t result;
    } probe_row_t;

    // predictor state: geometry as last written, kept depths in ascending order
    logic [DIM_BITS-1:0] win_cols = IMAGE_WIDTH_RST;
    logic [DIM_BITS-1:0] win_rows = IMAGE_HEIGHT_RST;
    logic [WIN_BITS-1:0] win_size = WINDOW_SIZE_RST;
    logic [DEPTH_BITS-1:0] sorted_depths[$];
    bit                    dropped_any = 1'b0;

    // medians still owed by the block, oldest first
    out_item_t expected_medians[$];
    out_item_t oldest_median;

    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;

    logic long_stall_req = 1'b0;
    logic long_stall_done = 1'b0;
    int   stall_left = 0;

    depth_window_median_top #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Half-open window [centre - radius, centre + radius), clamped to [0, limit).
    function automatic bit in_span(input int pos, input int centre, input int radius,
                                   input int limit);
        int lo;
        int hi;
        lo = centre - radius;
        hi = centre + radius;
        if (lo < 0) lo = 0;
        if (hi > limit) hi = limit;
        return (pos >= lo) && (pos < hi);
    endfunction

    // Fold one accepted beat into the predicted batch. On a last beat, hand back
    // the median of rank floor(count / 2) and empty the batch.
    task automatic track_sample(input in_item_t beat, output bit closes,
                                output out_item_t median);
        int radius;
        int pos;
        radius = int'(win_size) / 2;
        if (beat.depth_finite && beat.depth_mm != 0 &&
            in_span(int'(beat.sample_col), int'(beat.center_col), radius, int'(win_cols)) &&
            in_span(int'(beat.sample_row), int'(beat.center_row), radius, int'(win_rows))) begin
            if (sorted_depths.size() < STORE_DEPTH) begin
                pos = 0;
                while (pos < sorted_depths.size() && sorted_depths[pos] <= beat.depth_mm)
                    pos++;
                sorted_depths.insert(pos, beat.depth_mm);
            end else begin
                // store full: drop the sample, remember it
                dropped_any = 1'b1;
            end
        end
        closes = beat.last;
        median = '0;
        if (beat.last) begin
            if (sorted_depths.size() != 0) begin
                median.median_depth_mm = sorted_depths[sorted_depths.size() / 2];
                median.found = 1'b1;
            end
            median.overflow = dropped_any;
            sorted_depths.delete();
            dropped_any = 1'b0;
        end
    endtask

    // Offer one sample beat, holding it until accepted. Idle first at random.
    // Called at a rising edge; leaves at the edge that accepted the beat.
    task automatic offer_beat(input in_item_t beat, input bit typed, input out_item_t typed_res);
        int        gap;
        bit        closes;
        out_item_t median;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        track_sample(beat, closes, median);
        if (closes) expected_medians = {expected_medians, typed ? typed_res : median};
    endtask

    // Write all three registers back to back; valid stays high across the beats.
    task automatic program_registers(input logic [DIM_BITS-1:0] cols,
                                     input logic [DIM_BITS-1:0] rows,
                                     input logic [DIM_BITS-1:0] wsize);
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin
                    cfg_index <= REG_IMAGE_WIDTH;
                    cfg_data  <= cols;
                end
                1: begin
                    cfg_index <= REG_IMAGE_HEIGHT;
                    cfg_data  <= rows;
                end
                default: begin
                    cfg_index <= REG_WINDOW_SIZE;
                    cfg_data  <= wsize;
                end
            endcase
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            case (k)
                0: win_cols = cols;
                1: win_rows = rows;
                default: win_size = wsize[WIN_BITS-1:0];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Wait for every owed median, then let the block settle.
    task automatic drain_results();
        while (expected_medians.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Window centre: mostly inside the image, sometimes anywhere on 12 bits.
    function automatic int pick_centre(input int limit);
        if (limit == 0 || $urandom_range(99) < 15) return $urandom_range(4095);
        if (limit > 4096) return $urandom_range(4095);
        return $urandom_range(limit - 1);
    endfunction

    // Depth: zeros, the top code, small values that collide, full range.
    function automatic logic [DEPTH_BITS-1:0] pick_depth();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        if (roll < 50) return DEPTH_BITS'($urandom_range(1, 8));
        return DEPTH_BITS'($urandom_range(65535));
    endfunction

    function automatic int pick_batch_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return $urandom_range(1, 12);
        if (roll < 95) return $urandom_range(13, 40);
        return $urandom_range(41, 90);
    endfunction

    // Stream one batch ending in a last beat. A full batch puts every sample
    // inside the window with a valid depth, to fill the store exactly or overrun it.
    task automatic stream_batch(input int count, input bit full);
        in_item_t beat;
        int       radius;
        int       ccol;
        int       crow;
        int       cc;
        int       cr;
        radius = int'(win_size) / 2;
        ccol = pick_centre(int'(win_cols));
        crow = pick_centre(int'(win_rows));
        for (int i = 0; i < count; i++) begin
            beat = '0;
            if (full) begin
                beat.center_col   = 12'd100;
                beat.center_row   = 12'd100;
                beat.sample_col   = COORD_BITS'(100 + $urandom_range(0, 2 * radius - 1) - radius);
                beat.sample_row   = COORD_BITS'(100 + $urandom_range(0, 2 * radius - 1) - radius);
                beat.depth_mm     = DEPTH_BITS'($urandom_range(1, 65535));
                beat.depth_finite = 1'b1;
            end else begin
                cc = ccol;
                cr = crow;
                // stray beat with its own centre
                if ($urandom_range(99) < 5) begin
                    cc = $urandom_range(4095);
                    cr = $urandom_range(4095);
                end
                beat.center_col = COORD_BITS'(cc);
                beat.center_row = COORD_BITS'(cr);
                if ($urandom_range(99) < 75) begin
                    // around the window, one step past each edge
                    beat.sample_col = COORD_BITS'(cc + $urandom_range(0, 2 * radius + 1) - radius - 1);
                    beat.sample_row = COORD_BITS'(cr + $urandom_range(0, 2 * radius + 1) - radius - 1);
                end else begin
                    beat.sample_col = COORD_BITS'($urandom_range(4095));
                    beat.sample_row = COORD_BITS'($urandom_range(4095));
                end
                beat.depth_mm     = pick_depth();
                beat.depth_finite = ($urandom_range(99) < 92);
            end
            beat.last = (i == count - 1);
            offer_beat(beat, 1'b0, '0);
        end
    endtask

    // One setting of the registers and of the idling, then random batches and any full batch.
    task automatic run_phase(input logic [DIM_BITS-1:0] cols, input logic [DIM_BITS-1:0] rows,
                             input logic [DIM_BITS-1:0] wsize, input int send_pct,
                             input int recv_pct, input int budget, input int full_len);
        int sent;
        int count;
        bit full_done;
        drain_results();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        program_registers(cols, rows, wsize);
        sent = 0;
        full_done = (full_len == 0);
        while (sent < budget) begin
            if (!full_done && sent >= budget / 2) begin
                stream_batch(full_len, 1'b1);
                sent += full_len;
                full_done = 1'b1;
            end else begin
                count = pick_batch_len();
                stream_batch(count, 1'b0);
                sent += count;
            end
        end
        s_valid <= 1'b0;
    endtask

    function automatic probe_row_t probe(input int sc, input int sr, input int cc, input int cr,
                                         input int depth, input bit fin, input bit lst,
                                         input bit typed = 1'b0, input int med = 0,
                                         input bit fnd = 1'b0, input bit ovf = 1'b0);
        probe_row_t row;
        row.beat.sample_col      = COORD_BITS'(sc);
        row.beat.sample_row      = COORD_BITS'(sr);
        row.beat.center_col      = COORD_BITS'(cc);
        row.beat.center_row      = COORD_BITS'(cr);
        row.beat.depth_mm        = DEPTH_BITS'(depth);
        row.beat.depth_finite    = fin;
        row.beat.last            = lst;
        row.typed                = typed;
        row.result.median_depth_mm = DEPTH_BITS'(med);
        row.result.found         = fnd;
        row.result.overflow      = ovf;
        return row;
    endfunction

    // Receiver: random back-pressure, plus one long hold-off counted here so
    // the output register stays full and the block stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (long_stall_req && !long_stall_done) begin
            m_ready         <= 1'b0;
            stall_left      <= LONG_STALL;
            long_stall_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every result beat against the oldest owed median.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_medians.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: median %0d found %0b overflow %0b",
                             m_data.median_depth_mm, m_data.found, m_data.overflow);
            end else begin
                oldest_median = expected_medians.pop_front();
                if (m_data.median_depth_mm !== oldest_median.median_depth_mm ||
                    m_data.found !== oldest_median.found ||
                    m_data.overflow !== oldest_median.overflow) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected median %0d found %0b overflow %0b,",
                                  " got median %0d found %0b overflow %0b"},
                                 oldest_median.median_depth_mm, oldest_median.found,
                                 oldest_median.overflow, m_data.median_depth_mm,
                                 m_data.found, m_data.overflow);
                end
            end
        end
    end

    initial begin
        probe_row_t directed_rows[$];

        // Directed table under the reset geometry: 640 x 480, window 5 (radius 2).
        // Single-beat batches whose result is obvious carry it typed in.
        directed_rows = '{
            probe(10, 10, 10, 10, 0, 1, 1, 1, 0, 0, 0),          // no return
            probe(10, 10, 10, 10, 100, 0, 1, 1, 0, 0, 0),        // not finite
            probe(8, 8, 10, 10, 65535, 1, 1, 1, 65535, 1, 0),    // low corner
            probe(12, 10, 10, 10, 500, 1, 1, 1, 0, 0, 0),        // upper bound
            probe(7, 10, 10, 10, 500, 1, 1, 1, 0, 0, 0),         // below window
            probe(0, 0, 0, 0, 1, 1, 1, 1, 1, 1, 0),              // clamp at 0
            probe(639, 479, 639, 479, 7, 1, 1, 1, 7, 1, 0),      // image edge
            probe(4095, 4095, 4095, 4095, 9, 1, 1, 1, 0, 0, 0),  // off image
            // multi-beat batch with a repeated depth and a row just past the window
            probe(9, 9, 10, 10, 300, 1, 0),
            probe(10, 10, 10, 10, 100, 1, 0),
            probe(10, 12, 10, 10, 5, 1, 0),
            probe(11, 11, 10, 10, 200, 1, 0),
            probe(10, 9, 10, 10, 100, 1, 1),
            // high coordinate bits, centre outside the image
            probe(2048, 2048, 2049, 2047, 16'hAAAA, 1, 0),
            probe(2050, 2046, 2049, 2047, 16'h5555, 1, 0),
            probe(0, 4095, 2049, 2047, 1234, 1, 0),
            probe(2047, 2048, 2049, 2047, 16'hFFFF, 1, 1)
        };

        // hold reset, then release it on an edge
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idle share 22 percent, receiver 58 percent
        send_idle_pct = 22;
        recv_idle_pct = 58;
        foreach (directed_rows[i])
            offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);
        s_valid <= 1'b0;

        // reset geometry, one batch that fills the store exactly, one long hold-off
        drain_results();
        long_stall_req <= 1'b1;
        run_phase(13'd640, 13'd480, 13'd5, 22, 58, 480, STORE_DEPTH);
        // one-pixel image
        run_phase(13'd1, 13'd1, 13'd3, 22, 58, 80, 0);
        // largest legal geometry, one batch that overruns the store
        run_phase(13'd4096, 13'd4096, 13'd16, 58, 22, 480, STORE_DEPTH + 14);
        // zero width, widest height code, smallest window: nothing can be kept
        run_phase(13'd0, 13'd8191, 13'd1, 58, 22, 60, 0);
        // out-of-range width and window codes, used as written
        run_phase(13'd8191, 13'd4095, 13'd31, 0, 0, 350, 0);
        // small image, even window, no idling
        run_phase(13'd100, 13'd60, 13'd8, 0, 0, 420, 0);

        drain_results();
        if (mismatches == 0 && expected_medians.size() == 0) begin
            $display("tb_depth_window_median_top passed");
        end else begin
            $display("tb_depth_window_median_top failed");
        end
        $finish;
    end

    // Timeout: several times the slowest legal run.
    initial begin
        #2_000_000;
        $display("tb_depth_window_median_top failed");
        $finish;
    end

endmodule
